### design/bounded_linked_list_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded linked list engine
// Concurrent assertions sampled on clock and disabled during reset. They
// compile to nothing when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_LINKED_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_LINKED_LIST_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF

// Consequent must hold in the same cycle as the antecedent.
`define BLL_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BLL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define BLL_ASSERT_IMP(label, ante, cons, msg)

`define BLL_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### design/bll_pkg.sv
// ----------------------------------------------------------------------------
// Bounded linked list engine package
// Sizes, request and status codes and value conversion helpers shared by the
// channel interfaces and the engine.
// ----------------------------------------------------------------------------
package bll_pkg;

   // Pool size and stored value width.
   localparam int POOL_NODES = 16;
   localparam int VALUE_BITS = 32;

   // A read-out stops after this many results.
   localparam int MAX_OUT = 16;

   // Field widths fixed by the channel format.
   localparam int REQ_W      = 3;
   localparam int DATA_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int POSITION_W = 4;

   // Derived widths: a node index, and a link that can also hold the null marker.
   localparam int NODE_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam int LINK_W = $clog2(POOL_NODES + 1);
   localparam int POS_W  = (POOL_NODES > MAX_OUT) ? $clog2(POOL_NODES) : $clog2(MAX_OUT);

   typedef logic [NODE_W-1:0]             node_idx_type;
   typedef logic [LINK_W-1:0]             link_type;
   typedef logic [VALUE_BITS-1:0]         stored_type;
   typedef logic signed [DATA_W-1:0]      data_type;

   // The null link points one past the last node.
   localparam link_type NIL_LINK = link_type'(POOL_NODES);

   // Request codes.
   typedef enum logic [REQ_W-1:0] {
      REQ_INS_HEAD = 3'd0,
      REQ_INS_TAIL = 3'd1,
      REQ_SEARCH   = 3'd2,
      REQ_DELETE   = 3'd3,
      REQ_READOUT  = 3'd4,
      REQ_CLEAR    = 3'd5
   } req_code_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_NOT_FOUND  = 2'd1,
      ST_POOL_FULL  = 2'd2,
      ST_LIST_EMPTY = 2'd3
   } status_type;

   // Sign extend a channel value and keep the low VALUE_BITS bits.
   function automatic stored_type to_store(input data_type v);
      logic signed [63:0] wide;
      wide = 64'(v);
      return wide[VALUE_BITS-1:0];
   endfunction

   // Sign extend a stored value and return its low channel bits.
   function automatic data_type from_store(input stored_type s);
      logic signed [VALUE_BITS-1:0] ss;
      logic signed [63:0]           wide;
      ss   = s;
      wide = 64'(ss);
      return wide[DATA_W-1:0];
   endfunction

endpackage

### design/bll_if.sv
// ----------------------------------------------------------------------------
// Bounded linked list engine channels
// Valid/ready interfaces for the request channel and the response channel.
// ----------------------------------------------------------------------------

// Request channel: one request transaction per handshake.
interface bll_req_if import bll_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [REQ_W-1:0]         req_type;
   logic signed [DATA_W-1:0] data_value;

   modport source (output valid, output req_type, output data_value, input ready);
   modport sink   (input valid, input req_type, input data_value, output ready);
endinterface

// Response channel: one result transaction per handshake.
interface bll_rsp_if import bll_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [POSITION_W-1:0]    position;
   logic signed [DATA_W-1:0] item_value;
   logic                     last_of_run;

   modport source (output valid, output status, output position, output item_value,
                   output last_of_run, input ready);
   modport sink   (input valid, input status, input position, input item_value,
                   input last_of_run, output ready);
endinterface

### design/bounded_linked_list_engine.sv
// ----------------------------------------------------------------------------
// Bounded linked list engine
// Keeps an ordered list of signed values in a fixed pool of nodes and serves
// insert, search, delete, read-out and clear requests one at a time.
// ----------------------------------------------------------------------------
// Usage
// Requests arrive on req_if (req_type, data_value) and results leave on rsp_if
// (status, position, item_value, last_of_run); both are valid/ready channels.
// One request is in service at a time: req_if.ready is high only while the
// engine is idle. Every request except codes six and seven gives at least one
// result, and the final one carries last_of_run.
// Service steps: clear, full-pool and empty-list cases go straight to the
// result; an insert first claims the lowest free node, and a tail insert then
// walks the list to its last node; a search or delete walks from the head
// until it meets the value or the end. A read-out walks from the head and
// gives one result per cycle while the receiver does not stall. Each walk
// step waits for the registered read of the node and link memories. A
// result register decouples the sides: a waiting result does not stop the
// next request being accepted, but a stalled receiver holds a read-out walk
// and any request that must place its result.
// Reset empties the list and drops any pending result; node contents are not
// cleared.
// ----------------------------------------------------------------------------
module bounded_linked_list_engine import bll_pkg::*; (
   input logic       clock,
   input logic       reset,
   bll_req_if.sink   req_if,
   bll_rsp_if.source rsp_if
);

`include "bounded_linked_list_engine_assert.svh"

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_ALLOC = 4'b0010,
      S_WALK  = 4'b0100,
      S_EMIT  = 4'b1000
   } state_type;

   // Control state.
   state_type                 state_ff, state_in;
   logic [POOL_NODES-1:0]     used_ff, used_in;
   link_type                  first_ff, first_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Request context and walk registers.
   logic [REQ_W-1:0]          op_ff, op_in;
   stored_type                sval_ff, sval_in;
   link_type                  cur_ff, cur_in;
   link_type                  prev_ff, prev_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   node_idx_type              slot_ff, slot_in;
   status_type                res_status_ff, res_status_in;
   logic [POSITION_W-1:0]     res_pos_ff, res_pos_in;
   data_type                  res_value_ff, res_value_in;

   // Result register payload.
   status_type                rsp_status_ff, rsp_status_in;
   logic [POSITION_W-1:0]     rsp_pos_ff, rsp_pos_in;
   data_type                  rsp_value_ff, rsp_value_in;
   logic                      rsp_last_ff, rsp_last_in;

   // Node and link memories with registered read data.
   stored_type                node_mem [POOL_NODES];
   link_type                  link_mem [POOL_NODES];
   stored_type                node_rd_ff;
   link_type                  link_rd_ff;
   node_idx_type              rd_addr;
   logic                      node_we;
   node_idx_type              node_wa;
   stored_type                node_wd;
   logic                      link_we;
   node_idx_type              link_wa;
   link_type                  link_wd;

   // Helper signals.
   logic                      req_accept;
   logic                      rsp_free;
   logic                      pool_full;
   logic [POOL_NODES-1:0]     used_plus;
   logic [POOL_NODES-1:0]     free_onehot;
   node_idx_type              free_idx;
   logic [POOL_NODES-1:0]     cur_onehot;
   logic                      link_end;
   logic                      match;
   logic                      out_last;

   // Handshakes.
   assign req_if.ready = (state_ff == S_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   // Lowest free node: isolate the lowest clear bit of the used map.
   assign pool_full   = &used_ff;
   assign used_plus   = used_ff + POOL_NODES'(1);
   assign free_onehot = ~used_ff & used_plus;

   always_comb begin
      free_idx = '0;
      for (int i = 0; i < POOL_NODES; i++) begin
         if (free_onehot[i]) begin
            free_idx = free_idx | NODE_W'(i);
         end
      end
   end

   // Walk step decisions on the node just read.
   assign cur_onehot = POOL_NODES'(1) << cur_ff[NODE_W-1:0];
   assign link_end   = (link_rd_ff >= NIL_LINK);
   assign match      = (node_rd_ff == sval_ff);
   assign out_last   = link_end || (pos_ff == POS_W'(MAX_OUT - 1));

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      first_in      = first_ff;
      op_in         = op_ff;
      sval_in       = sval_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      pos_in        = pos_ff;
      slot_in       = slot_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_value_in  = res_value_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;

      rd_addr = first_ff[NODE_W-1:0];
      node_we = 1'b0;
      node_wa = free_idx;
      node_wd = sval_ff;
      link_we = 1'b0;
      link_wa = free_idx;
      link_wd = NIL_LINK;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in         = req_if.req_type;
               sval_in       = to_store(req_if.data_value);
               cur_in        = first_ff;
               prev_in       = NIL_LINK;
               pos_in        = '0;
               res_status_in = ST_OK;
               res_pos_in    = '0;
               res_value_in  = req_if.data_value;
               unique case (req_if.req_type) inside
                  REQ_INS_HEAD, REQ_INS_TAIL: begin
                     if (pool_full) begin
                        res_status_in = ST_POOL_FULL;
                        state_in      = S_EMIT;
                     end else begin
                        state_in = S_ALLOC;
                     end
                  end
                  REQ_SEARCH, REQ_DELETE: begin
                     if (first_ff >= NIL_LINK) begin
                        res_status_in = ST_NOT_FOUND;
                        state_in      = S_EMIT;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  REQ_READOUT: begin
                     if (first_ff >= NIL_LINK) begin
                        res_status_in = ST_LIST_EMPTY;
                        res_value_in  = '0;
                        state_in      = S_EMIT;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  REQ_CLEAR: begin
                     used_in  = '0;
                     first_in = NIL_LINK;
                     state_in = S_EMIT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // Claim the lowest free node; head insert or empty list links it in now.
         S_ALLOC: begin
            node_we = 1'b1;
            link_we = 1'b1;
            slot_in = free_idx;
            used_in = used_ff | free_onehot;
            if (op_ff == REQ_INS_HEAD || first_ff >= NIL_LINK) begin
               link_wd  = first_ff;
               first_in = link_type'(free_idx);
               state_in = S_EMIT;
            end else begin
               link_wd  = NIL_LINK;
               state_in = S_WALK;
            end
         end

         // One node per cycle unless a read-out waits on the receiver: the read data belongs to cur_ff.
         S_WALK: begin
            rd_addr = cur_ff[NODE_W-1:0];
            unique case (op_ff) inside
               REQ_INS_TAIL: begin
                  if (link_end) begin
                     link_we  = 1'b1;
                     link_wa  = cur_ff[NODE_W-1:0];
                     link_wd  = link_type'(slot_ff);
                     state_in = S_EMIT;
                  end else begin
                     cur_in  = link_rd_ff;
                     pos_in  = pos_ff + POS_W'(1);
                     rd_addr = link_rd_ff[NODE_W-1:0];
                  end
               end
               REQ_SEARCH, REQ_DELETE: begin
                  if (match) begin
                     res_status_in = ST_OK;
                     res_pos_in    = pos_ff[POSITION_W-1:0];
                     state_in      = S_EMIT;
                     if (op_ff == REQ_DELETE) begin
                        used_in = used_ff & ~cur_onehot;
                        if (prev_ff >= NIL_LINK) begin
                           first_in = link_rd_ff;
                        end else begin
                           link_we = 1'b1;
                           link_wa = prev_ff[NODE_W-1:0];
                           link_wd = link_rd_ff;
                        end
                     end
                  end else if (link_end) begin
                     res_status_in = ST_NOT_FOUND;
                     state_in      = S_EMIT;
                  end else begin
                     prev_in = cur_ff;
                     cur_in  = link_rd_ff;
                     pos_in  = pos_ff + POS_W'(1);
                     rd_addr = link_rd_ff[NODE_W-1:0];
                  end
               end
               REQ_READOUT: begin
                  if (rsp_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_pos_in    = pos_ff[POSITION_W-1:0];
                     rsp_value_in  = from_store(node_rd_ff);
                     rsp_last_in   = out_last;
                     if (out_last) begin
                        state_in = S_IDLE;
                     end else begin
                        cur_in  = link_rd_ff;
                        pos_in  = pos_ff + POS_W'(1);
                        rd_addr = link_rd_ff[NODE_W-1:0];
                     end
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         // Hand the single result of the request to the result register.
         S_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_value_in  = res_value_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         first_ff     <= NIL_LINK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      sval_ff       <= sval_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      pos_ff        <= pos_in;
      slot_ff       <= slot_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Node and link memories: one write port each, one registered read address.
   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_wa] <= node_wd;
      end
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      node_rd_ff <= node_mem[rd_addr];
      link_rd_ff <= link_mem[rd_addr];
   end

   // Response channel outputs.
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.position    = rsp_pos_ff;
   assign rsp_if.item_value  = rsp_value_ff;
   assign rsp_if.last_of_run = rsp_last_ff;

   // Checks.
   `BLL_ASSERT_IMP(a_head_link_in_range, 1'b1, first_ff <= NIL_LINK,
      "head link beyond null marker")
   `BLL_ASSERT_IMP(a_readout_run_open, rsp_valid_ff && !rsp_last_ff,
      state_ff == S_WALK && op_ff == REQ_READOUT,
      "open read-out result without an active walk")
   `BLL_ASSERT_NEXT(a_full_insert_flagged,
      req_accept && pool_full &&
      (req_if.req_type == REQ_INS_HEAD || req_if.req_type == REQ_INS_TAIL),
      state_ff == S_EMIT && res_status_ff == ST_POOL_FULL,
      "insert into full pool not flagged")
   `BLL_ASSERT_NEXT(a_delete_frees_one, state_ff == S_WALK && op_ff == REQ_DELETE && match,
      $countones(used_ff) == $countones($past(used_ff)) - 1,
      "delete did not free exactly one node")

endmodule

### test/bll_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list engine checker
// Watches the request and response channels of the engine and keeps its own
// copy of the node pool. Every accepted request updates that copy and queues
// the replies it must cause. Every accepted result is compared field by field
// with the oldest queued reply, and any difference is counted as a failure.
// ----------------------------------------------------------------------------
module bll_list_checker import bll_pkg::*; (
   input  logic clock,
   input  logic reset,
   bll_req_if   req_mon,
   bll_rsp_if   rsp_mon,
   output int   fail_count,
   output int   replies_outstanding,
   output int   requests_seen,
   output int   results_seen,
   output int   full_replies,
   output int   miss_replies
);

   // One reply as the engine should present it.
   typedef struct {
      status_type            status;
      logic [POSITION_W-1:0] position;
      data_type              item_value;
      logic                  last_of_run;
   } list_reply_type;

   // Shadow copy of the node pool and the list head.
   stored_type  slot_value [POOL_NODES];
   link_type    slot_next  [POOL_NODES];
   bit          slot_busy  [POOL_NODES];
   link_type    list_head;

   // Replies still owed by the engine, oldest first.
   list_reply_type list_replies [$];
   list_reply_type want;

   // Print one line per mismatch and count it.
   task report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
   endtask

   // Empty the list and free every node.
   function void clear_list();
      for (int i = 0; i < POOL_NODES; i++) begin
         slot_busy[i] = 1'b0;
         slot_next[i] = NIL_LINK;
      end
      list_head = NIL_LINK;
   endfunction

   function void note_reply(input status_type st, input int pos, input data_type value,
                            input bit last);
      list_reply_type r;
      r.status      = st;
      r.position    = POSITION_W'(pos);
      r.item_value  = value;
      r.last_of_run = last;
      list_replies.push_back(r);
   endfunction

   // Apply one request to the shadow list and queue the replies it causes.
   task automatic apply_list_request(input logic [REQ_W-1:0] code, input data_type value);
      stored_type key;
      link_type   walk;
      link_type   prior;
      link_type   fresh;
      int         hop;
      bit         hit;
      key = stored_type'(longint'(value));
      case (code) inside
         REQ_INS_HEAD, REQ_INS_TAIL: begin
            // A new node takes the lowest free slot.
            fresh = NIL_LINK;
            for (int i = 0; i < POOL_NODES; i++) begin
               if (!slot_busy[i] && fresh == NIL_LINK)
                  fresh = link_type'(i);
            end
            if (fresh == NIL_LINK) begin
               note_reply(ST_POOL_FULL, 0, value, 1'b1);
            end else begin
               slot_busy[fresh]  = 1'b1;
               slot_value[fresh] = key;
               slot_next[fresh]  = NIL_LINK;
               if (code == REQ_INS_HEAD || list_head == NIL_LINK) begin
                  slot_next[fresh] = list_head;
                  list_head        = fresh;
               end else begin
                  walk = list_head;
                  for (hop = 0; hop < POOL_NODES && slot_next[walk] != NIL_LINK; hop++)
                     walk = slot_next[walk];
                  slot_next[walk] = fresh;
               end
               note_reply(ST_OK, 0, value, 1'b1);
            end
         end
         REQ_SEARCH, REQ_DELETE: begin
            // Walk to the first node holding the key.
            walk  = list_head;
            prior = NIL_LINK;
            hit   = 1'b0;
            hop   = 0;
            while (walk != NIL_LINK && !hit && hop < POOL_NODES) begin
               if (slot_value[walk] == key) begin
                  hit = 1'b1;
               end else begin
                  prior = walk;
                  walk  = slot_next[walk];
                  hop++;
               end
            end
            if (!hit) begin
               note_reply(ST_NOT_FOUND, 0, value, 1'b1);
            end else begin
               if (code == REQ_DELETE) begin
                  if (prior == NIL_LINK)
                     list_head = slot_next[walk];
                  else
                     slot_next[prior] = slot_next[walk];
                  slot_busy[walk] = 1'b0;
                  slot_next[walk] = NIL_LINK;
               end
               note_reply(ST_OK, hop, value, 1'b1);
            end
         end
         REQ_READOUT: begin
            // One reply per node, the final one marked.
            if (list_head == NIL_LINK) begin
               note_reply(ST_LIST_EMPTY, 0, '0, 1'b1);
            end else begin
               walk = list_head;
               hop  = 0;
               while (walk != NIL_LINK && hop < MAX_OUT) begin
                  note_reply(ST_OK, hop, data_type'(longint'(signed'(slot_value[walk]))),
                             slot_next[walk] == NIL_LINK || hop + 1 == MAX_OUT);
                  walk = slot_next[walk];
                  hop++;
               end
            end
         end
         REQ_CLEAR: begin
            clear_list();
            note_reply(ST_OK, 0, value, 1'b1);
         end
         default: begin
            // Unused request codes are dropped without a reply.
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_list();
         list_replies.delete();
      end else begin
         // Compare a result transaction with the oldest owed reply.
         if (rsp_mon.valid && rsp_mon.ready) begin
            results_seen++;
            if (rsp_mon.status == ST_POOL_FULL)
               full_replies++;
            if (rsp_mon.status == ST_NOT_FOUND)
               miss_replies++;
            if (list_replies.size() == 0) begin
               report_mismatch($sformatf("result with none owed: status %0d value %0d",
                                         rsp_mon.status, rsp_mon.item_value));
            end else begin
               want = list_replies.pop_front();
               if (rsp_mon.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_mon.status, want.status));
               if (rsp_mon.position !== want.position)
                  report_mismatch($sformatf("position %0d, expected %0d",
                                            rsp_mon.position, want.position));
               if (rsp_mon.item_value !== want.item_value)
                  report_mismatch($sformatf("item_value %0d, expected %0d",
                                            rsp_mon.item_value, want.item_value));
               if (rsp_mon.last_of_run !== want.last_of_run)
                  report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                            rsp_mon.last_of_run, want.last_of_run));
            end
         end
         // Work out the replies of an accepted request transaction.
         if (req_mon.valid && req_mon.ready) begin
            requests_seen++;
            apply_list_request(req_mon.req_type, req_mon.data_value);
         end
      end
      replies_outstanding <= list_replies.size();
   end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked list engine testbench
// Drives directed and random request transactions into the engine with random
// sender gaps and receiver stalls, and leaves prediction and comparison to the
// checker beside it. The random part mostly builds, searches and trims lists,
// with bursts of inserts that run the pool full, and some clears and unused
// request codes as noise.
// ----------------------------------------------------------------------------
module testbench;
   import bll_pkg::*;

   // Request codes the engine does not serve.
   localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
   localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

   localparam int RANDOM_ITEMS = 136;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;

   logic     clock = 1'b0;
   logic     reset;
   int       send_idle_pct;
   int       recv_stall_pct;
   int       served_items;
   int       cycle_count = 0;
   data_type sent_values [$];

   int       fail_count;
   int       replies_outstanding;
   int       requests_seen;
   int       results_seen;
   int       full_replies;
   int       miss_replies;

   bll_req_if req_bus ();
   bll_rsp_if rsp_bus ();

   bounded_linked_list_engine i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   bll_list_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_mon             (req_bus),
      .rsp_mon             (rsp_bus),
      .fail_count          (fail_count),
      .replies_outstanding (replies_outstanding),
      .requests_seen       (requests_seen),
      .results_seen        (results_seen),
      .full_replies        (full_replies),
      .miss_replies        (miss_replies)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver stalls at random.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Abort a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d replies owed",
                  cycle_count, replies_outstanding);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Values mix extremes, small repeated numbers, earlier inserts and noise.
   function automatic data_type pick_value();
      case ($urandom_range(0, 9)) inside
         0: begin
            case ($urandom_range(0, 3))
               0:       return 32'sh7FFF_FFFF;
               1:       return 32'sh8000_0000;
               2:       return '0;
               default: return '1;
            endcase
         end
         1, 2:    return data_type'($urandom_range(0, 7));
         3, 4, 5: begin
            if (sent_values.size() != 0)
               return sent_values[$urandom_range(0, sent_values.size() - 1)];
            return data_type'($urandom);
         end
         default: return data_type'($urandom);
      endcase
   endfunction

   // Present one request transaction and hold it until it is accepted.
   task automatic send_request(input logic [REQ_W-1:0] code, input data_type value);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= code;
      req_bus.data_value <= value;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      if (code <= REQ_CLEAR)
         served_items++;
      if (code == REQ_INS_HEAD || code == REQ_INS_TAIL) begin
         sent_values.push_back(value);
         if (sent_values.size() > POOL_NODES)
            void'(sent_values.pop_front());
      end
   endtask

   // Insert until the pool overflows, then read the whole list back.
   task automatic fill_pool();
      repeat (POOL_NODES + 2)
         send_request($urandom_range(0, 1) ? REQ_INS_TAIL : REQ_INS_HEAD, pick_value());
      send_request(REQ_READOUT, pick_value());
   endtask

   initial begin
      int               random_done;
      int               phase;
      int               last_phase;
      int unsigned      roll;
      logic [REQ_W-1:0] code;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_INS_HEAD;
      req_bus.data_value = '0;
      send_idle_pct      = 9;
      recv_stall_pct     = 72;
      served_items       = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty list, extreme values, every position of a delete.
      send_request(REQ_READOUT,  32'sd0);
      send_request(REQ_SEARCH,   32'sd5);
      send_request(REQ_DELETE,   32'sd5);
      send_request(REQ_INS_HEAD, 32'sh7FFF_FFFF);
      send_request(REQ_INS_TAIL, 32'sh8000_0000);
      send_request(REQ_INS_HEAD, 32'sd0);
      send_request(REQ_INS_TAIL, -32'sd1);
      send_request(REQ_INS_TAIL, 32'sd0);
      send_request(REQ_READOUT,  32'sd0);
      send_request(REQ_SEARCH,   -32'sd1);
      send_request(REQ_SEARCH,   32'sd0);
      send_request(REQ_SEARCH,   32'sd12345);
      send_request(REQ_DELETE,   32'sd0);
      send_request(REQ_DELETE,   32'sh8000_0000);
      send_request(REQ_DELETE,   32'sd0);
      send_request(REQ_DELETE,   32'sd99);
      send_request(REQ_UNUSED_6, 32'sd1);
      send_request(REQ_UNUSED_7, -32'sd1);
      send_request(REQ_READOUT,  32'sd0);
      send_request(REQ_CLEAR,    32'sh55AA_55AA);
      send_request(REQ_READOUT,  32'sd0);
      send_request(REQ_INS_TAIL, 32'shA5A5_A5A5);
      send_request(REQ_READOUT,  32'sd0);

      // Random part in three pacing phases; each phase opens with a pool fill.
      random_done = 0;
      last_phase  = -1;
      served_items = 0;
      while (random_done < RANDOM_ITEMS) begin
         phase = random_done * 3 / RANDOM_ITEMS;
         case (phase)
            0:       begin send_idle_pct = 9;  recv_stall_pct = 72; end
            1:       begin send_idle_pct = 72; recv_stall_pct = 9;  end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         endcase
         if (phase != last_phase || $urandom_range(0, 99) < 5) begin
            fill_pool();
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 22)
               code = REQ_INS_HEAD;
            else if (roll < 44)
               code = REQ_INS_TAIL;
            else if (roll < 62)
               code = REQ_SEARCH;
            else if (roll < 80)
               code = REQ_DELETE;
            else if (roll < 91)
               code = REQ_READOUT;
            else if (roll < 95)
               code = REQ_CLEAR;
            else
               code = $urandom_range(0, 1) ? REQ_UNUSED_7 : REQ_UNUSED_6;
            send_request(code, pick_value());
         end
         last_phase  = phase;
         random_done = served_items;
      end

      // Drain: wait for every owed reply, then let the engine settle.
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (replies_outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d request and %0d result transactions in %0d cycles.",
               requests_seen, results_seen, cycle_count);
      $display("Among the results were %0d pool-full and %0d not-found replies.",
               full_replies, miss_replies);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### files.f
+incdir+design
design/bll_pkg.sv
design/bll_if.sv
design/bounded_linked_list_engine.sv
test/bll_list_checker.sv
test/testbench.sv
